// ----- sv/lcasr_pkg.sv -----
// Package for the load-cell converter serial reader.
// Holds word widths, sequence step limits and configuration register codes.
// No dependencies.
package lcasr_pkg;

  localparam int DATA_BITS  = 24;   // converter word width, 8 to 32
  localparam int RAW_FIELD  = 24;   // width of raw_reading and tare_offset
  localparam int WEIGHT_W   = 16;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Working width of the sign-extended word and of the tare.
  localparam int RAW_W  = (DATA_BITS > RAW_FIELD) ? DATA_BITS : RAW_FIELD;
  localparam int DIFF_W = RAW_W + 1;
  localparam int DCNT_W = $clog2(RAW_W);

  localparam int LAST_STEP = 2 * DATA_BITS + 2;
  localparam int STEP_W    = $clog2(LAST_STEP + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TARE_OFFSET   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = CFG_IDX_W'(1);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } rd_state_e;

  // Divider result handed back to the sequencer.
  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] quot;
  } div_res_t;

endpackage

// ----- sv/lcasr_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Keeps the low WEIGHT_W bits of the signed quotient.
// Depends on lcasr_pkg.
module lcasr_div import lcasr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIFF_W-1:0] diff_i,
  input  logic [SCALE_W-1:0]       divisor_i,
  output div_res_t                 res_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic [RAW_W-1:0]    dvd_q, dvd_d;
  logic [SCALE_W-1:0]  dsr_q, dsr_d;
  logic [SCALE_W-1:0]  rem_q, rem_d;
  logic [WEIGHT_W-1:0] quo_q, quo_d;

  logic [DIFF_W-1:0]   mag;
  logic [SCALE_W:0]    trial;
  logic [SCALE_W:0]    trial_sub;
  logic                fits;

  always_comb begin
    mag       = diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);
    trial     = {rem_q, dvd_q[RAW_W-1]};
    trial_sub = trial - {1'b0, dsr_q};
    fits      = (trial >= {1'b0, dsr_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = diff_i[DIFF_W-1];
      dvd_d  = mag[RAW_W-1:0];
      // a zero scale divides by one
      dsr_d  = (divisor_i == '0) ? SCALE_W'(1) : divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[RAW_W-2:0], 1'b0};
      rem_d = fits ? trial_sub[SCALE_W-1:0] : trial[SCALE_W-1:0];
      // older quotient bits fall off the top: only the low bits are kept
      quo_d = {quo_q[WEIGHT_W-2:0], fits};
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(RAW_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_comb begin
    res_o.done = done_q;
    res_o.quot = neg_q ? WEIGHT_W'(~quo_q + WEIGHT_W'(1)) : quo_q;
  end

endmodule

// ----- sv/load_cell_adc_serial_reader.sv -----
// Top level of the load-cell converter serial reader.
// Sequencer, shift register, held results and output register; uses lcasr_div.
// Depends on lcasr_pkg.

// Each input transaction is one tick of the converter's two-wire sequence and
// yields exactly one output transaction carrying the clock level for that tick,
// the done flag and the held raw and weight values. Ticks are taken one per
// cycle while the output register is free or being drained and no division
// is running. The completing tick waits while the restoring divider
// produces one quotient bit per cycle, before the result is registered.
// Configuration writes are always ready; index 0 is the tare offset, index 1
// the scale divisor, other indexes are ignored.
module load_cell_adc_serial_reader import lcasr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        data_pin_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        clock_pin_o,
  output logic                        sample_done_o,
  output logic signed [RAW_FIELD-1:0] raw_reading_o,
  output logic [WEIGHT_W-1:0]         weight_o
);

  rd_state_e state_q, state_d;

  logic [STEP_W-1:0]           step_q, step_d;
  logic [DATA_BITS-1:0]        shift_q, shift_d;
  logic signed [RAW_FIELD-1:0] raw_q, raw_d;
  logic [WEIGHT_W-1:0]         weight_q, weight_d;
  logic signed [RAW_FIELD-1:0] tare_q;
  logic [SCALE_W-1:0]          scale_q;
  logic                        out_valid_q, out_valid_d;
  logic                        clk_pin_q, clk_pin_d;
  logic                        done_q, done_d;

  logic                        in_acc;
  logic                        out_free;
  logic                        at_idle, at_last;
  logic                        div_start;
  logic                        out_load;
  div_res_t                    div_res;

  logic signed [DATA_BITS-1:0] word_s;
  logic signed [RAW_W-1:0]     raw_ext;
  logic signed [RAW_W-1:0]     tare_ext;
  logic signed [DIFF_W-1:0]    diff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_q  <= '0;
      scale_q <= SCALE_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TARE_OFFSET) begin
        tare_q <= cfg_data_i[RAW_FIELD-1:0];
      end else if (cfg_index_i == REG_SCALE_DIVISOR) begin
        scale_q <= cfg_data_i[SCALE_W-1:0];
      end
    end
  end

  always_comb begin
    word_s   = shift_q;
    raw_ext  = RAW_W'(word_s);
    tare_ext = RAW_W'(tare_q);
    diff     = DIFF_W'(raw_ext) - DIFF_W'(tare_ext);
    at_idle  = (step_q == '0);
    at_last  = (step_q == STEP_W'(LAST_STEP));
    out_free = !out_valid_q || out_ready_i;
    in_acc   = in_valid_i && in_ready_o;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: if (in_acc && at_last) state_d = ST_DIV;
      ST_DIV: if (div_res.done) state_d = ST_RUN;
      default: state_d = ST_RUN;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        in_ready_o = out_free;
        div_start  = in_acc && at_last;
        out_load   = in_acc && !at_last;
      end
      ST_DIV: out_load = div_res.done;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    step_d      = step_q;
    shift_d     = shift_q;
    raw_d       = raw_q;
    weight_d    = weight_q;
    clk_pin_d   = clk_pin_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (in_acc && !at_last) begin
      clk_pin_d = 1'b0;
      done_d    = 1'b0;
      if (at_idle) begin
        if (!data_pin_i) begin
          shift_d = '0;
          step_d  = STEP_W'(1);
        end
      end else begin
        if (step_q[0]) begin
          clk_pin_d = 1'b1;
          // the gain pulse shifts nothing
          if (step_q < STEP_W'(2 * DATA_BITS)) begin
            shift_d = {shift_q[DATA_BITS-2:0], data_pin_i};
          end
        end
        step_d = step_q + STEP_W'(1);
      end
    end
    if (state_q == ST_DIV && div_res.done) begin
      raw_d     = raw_ext[RAW_FIELD-1:0];
      weight_d  = div_res.quot;
      clk_pin_d = 1'b0;
      done_d    = 1'b1;
      step_d    = '0;
    end
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      step_q      <= '0;
      shift_q     <= '0;
      raw_q       <= '0;
      weight_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      shift_q     <= shift_d;
      raw_q       <= raw_d;
      weight_q    <= weight_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clk_pin_q <= clk_pin_d;
    done_q    <= done_d;
  end

  lcasr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .diff_i    (diff),
    .divisor_i (scale_q),
    .res_o     (div_res)
  );

  assign out_valid_o   = out_valid_q;
  assign clock_pin_o   = clk_pin_q;
  assign sample_done_o = done_q;
  assign raw_reading_o = raw_q;
  assign weight_o      = weight_q;

endmodule
